[sv/xyr_pkg.sv]
// ----------------------------------------------------------------------------
// xyr_pkg
// Shared constants and controller/datapath interface types for the XY route
// generator.
// ----------------------------------------------------------------------------
package xyr_pkg;

    localparam int NODE_W          = 6;
    localparam int CFG_W           = 4;
    localparam int DEF_MAX_WIDTH   = 8;
    localparam int MESH_WIDTH_RST  = 8;
    localparam int DIV_STEPS       = NODE_W;
    localparam int CNT_W           = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic div_step;
        logic hop;
    } xyr_cmd_t;

    typedef struct packed {
        logic bad;
        logic route_done;
        logic out_free;
    } xyr_stat_t;

endpackage

[sv/xyr_ctrl.sv]
// ----------------------------------------------------------------------------
// xyr_ctrl
// Sequencer: request capture, coordinate decode steps, hop emission.
// ----------------------------------------------------------------------------
module xyr_ctrl
    import xyr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  xyr_stat_t stat,
    output xyr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_ROUTE = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.bad)
                begin
                    state_next = ST_ROUTE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_next = ST_ROUTE;
                    end
                end
            end
            ST_ROUTE:
            begin
                if (stat.out_free)
                begin
                    cmd.hop = 1'b1;
                    if (stat.route_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_DIV)
        else $error("request accepted but decode not started");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg < CNT_W'(DIV_STEPS))
        else $error("decode step count overran");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUTE && stat.out_free && stat.route_done |=> in_ready)
        else $error("not ready after final hop");

endmodule

[sv/xyr_dpath.sv]
// ----------------------------------------------------------------------------
// xyr_dpath
// Restoring division of both nodes by the mesh width, hop stepping and the
// result register.
// ----------------------------------------------------------------------------
module xyr_dpath
    import xyr_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CFG_W-1:0]  mesh_width,
    input  logic [NODE_W-1:0] src_node,
    input  logic [NODE_W-1:0] dest_node,
    input  xyr_cmd_t          cmd,
    output xyr_stat_t         stat,
    output logic [NODE_W-1:0] node_id,
    output logic              last,
    output logic              bad_request,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (2 * WW > NODE_W) ? 2 * WW : NODE_W;

    logic [WW-1:0]     w_eff;
    logic [CW-1:0]     nodes;
    logic              bad_in;

    logic [WW-1:0]     w_reg;
    logic              bad_reg;
    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] node_next;
    logic [NODE_W-1:0] dst_reg;
    logic [NODE_W-1:0] q_s_reg;
    logic [NODE_W-1:0] q_s_next;
    logic [NODE_W-1:0] q_d_reg;
    logic [NODE_W-1:0] q_d_next;
    logic [WW-1:0]     rem_s_reg;
    logic [WW-1:0]     rem_s_next;
    logic [WW-1:0]     rem_d_reg;
    logic [WW-1:0]     rem_d_next;

    logic [WW:0]       t_s;
    logic [WW:0]       t_d;
    logic [WW:0]       sub_s;
    logic [WW:0]       sub_d;
    logic              ge_s;
    logic              ge_d;

    logic              col_eq;
    logic              row_eq;
    logic              at_dest;
    logic [NODE_W-1:0] node_w;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [NODE_W-1:0] out_node_reg;
    logic              out_last_reg;
    logic              out_bad_reg;

    // width 0 behaves as 1, above the maximum as the maximum
    always_comb
    begin
        if (mesh_width == '0)
        begin
            w_eff = WW'(1);
        end
        else if (int'(mesh_width) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(mesh_width);
        end
    end

    assign nodes  = CW'(w_eff) * CW'(w_eff);
    assign bad_in = (CW'(src_node) >= nodes) || (CW'(dest_node) >= nodes);

    assign t_s   = {rem_s_reg, q_s_reg[NODE_W-1]};
    assign t_d   = {rem_d_reg, q_d_reg[NODE_W-1]};
    assign sub_s = t_s - {1'b0, w_reg};
    assign sub_d = t_d - {1'b0, w_reg};
    assign ge_s  = (t_s >= {1'b0, w_reg});
    assign ge_d  = (t_d >= {1'b0, w_reg});

    assign col_eq  = (rem_s_reg == rem_d_reg);
    assign row_eq  = (q_s_reg == q_d_reg);
    assign at_dest = col_eq && row_eq;
    assign node_w  = NODE_W'(w_reg);

    assign out_valid_next = cmd.hop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign stat.bad        = bad_reg;
    assign stat.route_done = bad_reg || at_dest;
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        q_s_next   = q_s_reg;
        q_d_next   = q_d_reg;
        rem_s_next = rem_s_reg;
        rem_d_next = rem_d_reg;
        node_next  = node_reg;
        priority if (cmd.load)
        begin
            q_s_next   = src_node;
            q_d_next   = dest_node;
            rem_s_next = '0;
            rem_d_next = '0;
            node_next  = src_node;
        end
        else if (cmd.div_step)
        begin
            q_s_next   = {q_s_reg[NODE_W-2:0], ge_s};
            q_d_next   = {q_d_reg[NODE_W-2:0], ge_d};
            rem_s_next = ge_s ? sub_s[WW-1:0] : t_s[WW-1:0];
            rem_d_next = ge_d ? sub_d[WW-1:0] : t_d[WW-1:0];
        end
        else if (cmd.hop && !bad_reg && !col_eq)
        begin
            // along the row
            if (rem_d_reg > rem_s_reg)
            begin
                rem_s_next = rem_s_reg + WW'(1);
                node_next  = node_reg + NODE_W'(1);
            end
            else
            begin
                rem_s_next = rem_s_reg - WW'(1);
                node_next  = node_reg - NODE_W'(1);
            end
        end
        else if (cmd.hop && !bad_reg && !row_eq)
        begin
            // along the column
            if (q_d_reg > q_s_reg)
            begin
                q_s_next  = q_s_reg + NODE_W'(1);
                node_next = node_reg + node_w;
            end
            else
            begin
                q_s_next  = q_s_reg - NODE_W'(1);
                node_next = node_reg - node_w;
            end
        end
        else
        begin
            // hold
            node_next = node_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg   <= w_eff;
            bad_reg <= bad_in;
            dst_reg <= dest_node;
        end
        q_s_reg   <= q_s_next;
        q_d_reg   <= q_d_next;
        rem_s_reg <= rem_s_next;
        rem_d_reg <= rem_d_next;
        node_reg  <= node_next;
        if (cmd.hop)
        begin
            out_node_reg <= bad_reg ? '0 : (at_dest ? dst_reg : node_reg);
            out_last_reg <= bad_reg || at_dest;
            out_bad_reg  <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign node_id     = out_node_reg;
    assign last        = out_last_reg;
    assign bad_request = out_bad_reg;

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_request |-> last && node_id == '0)
        else $error("bad request result not a lone zero node");

    a_hop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hop && !stat.route_done |=> node_reg != $past(node_reg))
        else $error("intermediate hop did not move");

endmodule

[sv/mesh_xy_route_generator.sv]
// ----------------------------------------------------------------------------
// mesh_xy_route_generator
// XY dimension-order route generator for a square 2D mesh of configurable side.
// Sequence: the request is taken, 6 restoring-division steps decode the nodes, then
// each hop goes through 1 output register; a bad request skips the division.
// Throughput: one hop per cycle is emitted while the output is not stalled; a new
// request is taken only once the last hop of the previous one has been emitted.
// Reset: asynchronous, clears the sequencer and output valid; width goes to 8.
// ----------------------------------------------------------------------------
module mesh_xy_route_generator
    import xyr_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,   // mesh_width
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,     // [5:0] src_node, [11:6] dest_node, rest zero
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,     // [5:0] node_id, rest zero
    output logic             m_tlast,
    output logic             m_tuser      // [0] bad_request
);

    logic [CFG_W-1:0]  mesh_width_reg;
    logic [NODE_W-1:0] node_id;
    xyr_cmd_t          cmd;
    xyr_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_width_reg <= CFG_W'(MESH_WIDTH_RST);
        end
        else if (cfg_we)
        begin
            mesh_width_reg <= cfg_wdata;
        end
    end

    xyr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    xyr_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mesh_width  (mesh_width_reg),
        .src_node    (s_tdata[NODE_W-1:0]),
        .dest_node   (s_tdata[2*NODE_W-1:NODE_W]),
        .cmd         (cmd),
        .stat        (stat),
        .node_id     (node_id),
        .last        (m_tlast),
        .bad_request (m_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tdata = {{(8 - NODE_W){1'b0}}, node_id};

endmodule
